### rtl/console_escape_key_decoder_top_defines.svh
// ----------------------------------------------------------------------------
// Console escape key decoder: assertion macros
// Shared concurrent assertion helpers for the decoder RTL.
// ----------------------------------------------------------------------------
`ifndef CONSOLE_ESCAPE_KEY_DECODER_TOP_DEFINES_SVH
`define CONSOLE_ESCAPE_KEY_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define CKD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ckd assertion failed");

// Next-cycle implication, disabled while reset is high.
`define CKD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ckd assertion failed");

`endif

### rtl/ckd_pkg.sv
// ----------------------------------------------------------------------------
// ckd_pkg
// Types, codes and constants shared by the console escape key decoder.
// ----------------------------------------------------------------------------
package ckd_pkg;

   // Parameter store geometry.
   localparam int PARAM_COUNT = 10;
   localparam int IDX_W       = $clog2(PARAM_COUNT);
   localparam int SLOT_W      = $clog2(PARAM_COUNT + 1);

   // Special input bytes.
   localparam logic [7:0] BYTE_ESC   = 8'd27;
   localparam logic [7:0] BYTE_CSI   = 8'd155;
   localparam logic [7:0] CH_LBRACK  = 8'h5B;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_QUEST   = 8'h3F;
   localparam logic [7:0] CH_AT      = 8'h40;
   localparam logic [7:0] CH_0       = 8'h30;
   localparam logic [7:0] CH_9       = 8'h39;
   localparam logic [7:0] CH_SEMI    = 8'h3B;
   localparam logic [7:0] CH_TILDE   = 8'h7E;
   localparam logic [7:0] CH_BAR     = 8'h7C;
   localparam logic [7:0] CH_A       = 8'h41;
   localparam logic [7:0] CH_B       = 8'h42;
   localparam logic [7:0] CH_C       = 8'h43;
   localparam logic [7:0] CH_D       = 8'h44;
   localparam logic [7:0] CH_S       = 8'h53;
   localparam logic [7:0] CH_T       = 8'h54;
   localparam logic [7:0] CH_Z       = 8'h5A;

   // Key codes and offsets.
   localparam logic [31:0] KEY_UP         = 32'd256;
   localparam logic [31:0] KEY_DOWN       = 32'd257;
   localparam logic [31:0] KEY_RIGHT      = 32'd258;
   localparam logic [31:0] KEY_LEFT       = 32'd259;
   localparam logic [31:0] KEY_HELP       = 32'd260;
   localparam logic [31:0] KEY_FKEY_BASE  = 32'd261;
   localparam logic [31:0] KEY_FKEY_LAST  = 32'd270;
   localparam logic [31:0] KEY_EVENT      = 32'd271;
   localparam logic [31:0] KEY_TAB        = 32'd9;
   localparam logic [31:0] SHIFT_ADD      = 32'd512;
   localparam logic [31:0] FKEY_SHIFT_ADD = 32'd502;
   localparam logic [31:0] ESC_ADD        = 32'd1024;

   // Result status codes.
   localparam logic [1:0] STATUS_KEY     = 2'd0;
   localparam logic [1:0] STATUS_END     = 2'd1;
   localparam logic [1:0] STATUS_END_SEQ = 2'd2;

   // Parser modes.
   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_ESC,
      MODE_CSI,
      MODE_SPACE,
      MODE_HELP,
      MODE_PARAM,
      MODE_SKIP
   } mode_type;

   // Request payload.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_input;
   } req_type;

   // Response payload.
   typedef struct packed {
      logic [31:0] key_code;
      logic [31:0] first_param;
      logic [31:0] third_param;
      logic [1:0]  status;
   } rsp_type;

   // Registered request handed to the parser.
   typedef struct packed {
      logic    valid;
      req_type req;
   } stage_type;

   // Parser result handed to the output register.
   typedef struct packed {
      logic    valid;
      rsp_type rsp;
   } result_type;

endpackage

### rtl/ckd_in_stage.sv
// ----------------------------------------------------------------------------
// ckd_in_stage
// Input register: holds one request until the parser consumes it.
// ----------------------------------------------------------------------------
module ckd_in_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  ckd_pkg::req_type   req_data,
   input  logic               take,
   output ckd_pkg::stage_type item
);

   logic             valid_ff;
   logic             valid_in;
   ckd_pkg::req_type data_ff;

   // The register frees up when it is empty or its request is consumed.
   assign req_ready = !valid_ff || take;

   always_comb begin
      valid_in = valid_ff;
      if (req_ready) begin
         valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload carries no reset.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         data_ff <= req_data;
      end
   end

   assign item.valid = valid_ff;
   assign item.req   = data_ff;

endmodule

### rtl/ckd_parser.sv
// ----------------------------------------------------------------------------
// ckd_parser
// Escape sequence state machine, parameter store and key code formation.
// ----------------------------------------------------------------------------
`include "console_escape_key_decoder_top_defines.svh"

module ckd_parser (
   input  logic                clock,
   input  logic                reset,
   input  ckd_pkg::stage_type  item,
   input  logic                take,
   output ckd_pkg::result_type result
);

   ckd_pkg::mode_type             mode_ff;
   ckd_pkg::mode_type             mode_in;
   logic                          escape_ff;
   logic                          escape_in;
   logic [ckd_pkg::SLOT_W-1:0]    slot_ff;
   logic [ckd_pkg::SLOT_W-1:0]    slot_in;
   logic [31:0]                   store_ff [ckd_pkg::PARAM_COUNT];

   logic                          fire;
   logic [7:0]                    c;
   logic                          eoi;
   logic                          is_digit;
   logic                          is_inter;
   logic [31:0]                   digit_val;
   logic                          slot_ok;
   logic [ckd_pkg::SLOT_W-1:0]    slot_inc;
   logic                          inc_ok;
   logic [31:0]                   cur_val;
   logic [31:0]                   mul10;
   logic [31:0]                   fkey_sum;
   logic [31:0]                   fkey;

   logic                          emit;
   logic                          add_esc;
   logic [31:0]                   key_base;
   logic [31:0]                   p0;
   logic [31:0]                   p2;
   logic [1:0]                    st;
   logic                          store_we;
   logic [ckd_pkg::IDX_W-1:0]     store_idx;
   logic [31:0]                   store_wdata;

   // Decode of the current byte.
   assign fire      = item.valid && take;
   assign c         = item.req.data_byte;
   assign eoi       = item.req.end_of_input;
   assign is_digit  = c inside {[ckd_pkg::CH_0:ckd_pkg::CH_9]};
   assign is_inter  = c inside {[ckd_pkg::CH_SPACE:ckd_pkg::CH_QUEST]};
   assign digit_val = {28'd0, c[3:0]};

   // Parameter slot bookkeeping; the slot saturates at the store depth.
   assign slot_ok  = slot_ff < ckd_pkg::SLOT_W'(ckd_pkg::PARAM_COUNT);
   assign slot_inc = slot_ok ? slot_ff + ckd_pkg::SLOT_W'(1) : slot_ff;
   assign inc_ok   = slot_inc < ckd_pkg::SLOT_W'(ckd_pkg::PARAM_COUNT);

   // Decimal accumulation: value times ten plus the new digit, wrapping.
   assign cur_val = slot_ok ? store_ff[slot_ff[ckd_pkg::IDX_W-1:0]] : 32'd0;
   assign mul10   = (cur_val << 3) + (cur_val << 1) + digit_val;

   // Function key number; keys past the last plain one move to shifted codes.
   assign fkey_sum = store_ff[0] + ckd_pkg::KEY_FKEY_BASE;
   assign fkey     = (fkey_sum > ckd_pkg::KEY_FKEY_LAST) ?
                     fkey_sum + ckd_pkg::FKEY_SHIFT_ADD : fkey_sum;

   // Output logic: result fields and parameter store writes.
   always_comb begin
      emit        = 1'b0;
      add_esc     = 1'b0;
      key_base    = 32'd0;
      p0          = 32'd0;
      p2          = 32'd0;
      st          = ckd_pkg::STATUS_KEY;
      store_we    = 1'b0;
      store_idx   = '0;
      store_wdata = 32'd0;
      slot_in     = slot_ff;
      if (eoi) begin
         emit = 1'b1;
         case (mode_ff)
            ckd_pkg::MODE_HELP: begin
               key_base = ckd_pkg::KEY_HELP;
               add_esc  = 1'b1;
            end
            ckd_pkg::MODE_CSI, ckd_pkg::MODE_SPACE,
            ckd_pkg::MODE_PARAM, ckd_pkg::MODE_SKIP: begin
               st = ckd_pkg::STATUS_END_SEQ;
            end
            default: begin
               st = ckd_pkg::STATUS_END;
            end
         endcase
      end else begin
         case (mode_ff)
            ckd_pkg::MODE_IDLE: begin
               if (c != ckd_pkg::BYTE_ESC && c != ckd_pkg::BYTE_CSI) begin
                  emit     = 1'b1;
                  add_esc  = 1'b1;
                  key_base = {24'd0, c};
               end
            end
            ckd_pkg::MODE_ESC: begin
               if (c != ckd_pkg::CH_LBRACK && c != ckd_pkg::BYTE_CSI) begin
                  emit     = 1'b1;
                  add_esc  = 1'b1;
                  key_base = {24'd0, c};
               end
            end
            ckd_pkg::MODE_CSI: begin
               if (is_digit) begin
                  slot_in     = '0;
                  store_we    = 1'b1;
                  store_idx   = '0;
                  store_wdata = digit_val;
               end else if (c != ckd_pkg::CH_SPACE && c != ckd_pkg::CH_QUEST) begin
                  emit    = 1'b1;
                  add_esc = 1'b1;
                  case (c)
                     ckd_pkg::CH_A: key_base = ckd_pkg::KEY_UP;
                     ckd_pkg::CH_B: key_base = ckd_pkg::KEY_DOWN;
                     ckd_pkg::CH_C: key_base = ckd_pkg::KEY_RIGHT;
                     ckd_pkg::CH_D: key_base = ckd_pkg::KEY_LEFT;
                     ckd_pkg::CH_T: key_base = ckd_pkg::KEY_UP + ckd_pkg::SHIFT_ADD;
                     ckd_pkg::CH_S: key_base = ckd_pkg::KEY_DOWN + ckd_pkg::SHIFT_ADD;
                     ckd_pkg::CH_Z: key_base = ckd_pkg::KEY_TAB + ckd_pkg::SHIFT_ADD;
                     default:       key_base = {24'd0, c};
                  endcase
               end
            end
            ckd_pkg::MODE_SPACE: begin
               if (c == ckd_pkg::CH_AT) begin
                  emit     = 1'b1;
                  add_esc  = 1'b1;
                  key_base = ckd_pkg::KEY_RIGHT + ckd_pkg::SHIFT_ADD;
               end else if (c == ckd_pkg::CH_A) begin
                  emit     = 1'b1;
                  add_esc  = 1'b1;
                  key_base = ckd_pkg::KEY_LEFT + ckd_pkg::SHIFT_ADD;
               end
            end
            ckd_pkg::MODE_HELP: begin
               emit     = 1'b1;
               add_esc  = 1'b1;
               key_base = ckd_pkg::KEY_HELP;
            end
            ckd_pkg::MODE_PARAM: begin
               if (is_digit) begin
                  store_we    = slot_ok;
                  store_idx   = slot_ff[ckd_pkg::IDX_W-1:0];
                  store_wdata = mul10;
               end else if (c == ckd_pkg::CH_SEMI) begin
                  slot_in     = slot_inc;
                  store_we    = inc_ok;
                  store_idx   = slot_inc[ckd_pkg::IDX_W-1:0];
                  store_wdata = 32'd0;
               end else if (c == ckd_pkg::CH_TILDE) begin
                  emit     = 1'b1;
                  add_esc  = 1'b1;
                  key_base = fkey;
                  p0       = store_ff[0];
               end else if (c == ckd_pkg::CH_BAR) begin
                  emit     = 1'b1;
                  add_esc  = 1'b1;
                  key_base = ckd_pkg::KEY_EVENT;
                  p0       = store_ff[0];
                  p2       = store_ff[2];
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Next state logic for the mode and the escape mark.
   always_comb begin
      mode_in   = ckd_pkg::MODE_IDLE;
      escape_in = escape_ff;
      if (eoi) begin
         escape_in = 1'b0;
      end else begin
         case (mode_ff)
            ckd_pkg::MODE_IDLE: begin
               if (c == ckd_pkg::BYTE_ESC) begin
                  mode_in   = ckd_pkg::MODE_ESC;
                  escape_in = 1'b1;
               end else if (c == ckd_pkg::BYTE_CSI) begin
                  mode_in = ckd_pkg::MODE_CSI;
               end
            end
            ckd_pkg::MODE_ESC: begin
               if (c == ckd_pkg::CH_LBRACK) begin
                  mode_in   = ckd_pkg::MODE_CSI;
                  escape_in = 1'b0;
               end else if (c == ckd_pkg::BYTE_CSI) begin
                  mode_in = ckd_pkg::MODE_CSI;
               end
            end
            ckd_pkg::MODE_CSI: begin
               if (c == ckd_pkg::CH_SPACE) begin
                  mode_in = ckd_pkg::MODE_SPACE;
               end else if (c == ckd_pkg::CH_QUEST) begin
                  mode_in = ckd_pkg::MODE_HELP;
               end else if (is_digit) begin
                  mode_in = ckd_pkg::MODE_PARAM;
               end
            end
            ckd_pkg::MODE_PARAM: begin
               if (is_digit || c == ckd_pkg::CH_SEMI) begin
                  mode_in = ckd_pkg::MODE_PARAM;
               end else if (is_inter) begin
                  mode_in = ckd_pkg::MODE_SKIP;
               end
            end
            ckd_pkg::MODE_SKIP: begin
               if (is_inter) begin
                  mode_in = ckd_pkg::MODE_SKIP;
               end
            end
            default: begin
            end
         endcase
         // Any delivered key ends the sequence and clears the mark.
         if (emit) begin
            mode_in   = ckd_pkg::MODE_IDLE;
            escape_in = 1'b0;
         end
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= ckd_pkg::MODE_IDLE;
         escape_ff <= 1'b0;
         slot_ff   <= '0;
      end else if (fire) begin
         mode_ff   <= mode_in;
         escape_ff <= escape_in;
         slot_ff   <= slot_in;
      end
   end

   // Parameter store; cleared by reset since untouched slots are visible.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ckd_pkg::PARAM_COUNT; i++) begin
            store_ff[i] <= 32'd0;
         end
      end else if (fire && store_we) begin
         store_ff[store_idx] <= store_wdata;
      end
   end

   // Result toward the output register.
   assign result.valid           = fire && emit;
   assign result.rsp.key_code    = key_base +
                                   ((add_esc && escape_ff) ? ckd_pkg::ESC_ADD : 32'd0);
   assign result.rsp.first_param = p0;
   assign result.rsp.third_param = p2;
   assign result.rsp.status      = st;

   // An end of input always produces a result and returns the parser to idle.
   `CKD_ASSERT_SAME(a_eoi_result, clock, reset, fire && eoi, result.valid)
   `CKD_ASSERT_NEXT(a_eoi_idle, clock, reset, fire && eoi,
                    mode_ff == ckd_pkg::MODE_IDLE && !escape_ff)
   // A delivered result always clears the escape mark.
   `CKD_ASSERT_NEXT(a_emit_clears_mark, clock, reset, result.valid, !escape_ff)
   // The slot never runs past the store depth.
   `CKD_ASSERT_SAME(a_slot_range, clock, reset, 1'b1,
                    slot_ff <= ckd_pkg::SLOT_W'(ckd_pkg::PARAM_COUNT))

endmodule

### rtl/ckd_out_stage.sv
// ----------------------------------------------------------------------------
// ckd_out_stage
// Result register: holds one response until the consumer takes it.
// ----------------------------------------------------------------------------
module ckd_out_stage (
   input  logic                clock,
   input  logic                reset,
   input  ckd_pkg::result_type result,
   output logic                take,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output ckd_pkg::rsp_type    rsp_data
);

   logic             valid_ff;
   logic             valid_in;
   ckd_pkg::rsp_type data_ff;

   // The register can load when empty or when its response leaves this cycle.
   assign take = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && result.valid) begin
         data_ff <= result.rsp;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

### rtl/console_escape_key_decoder_top.sv
// ----------------------------------------------------------------------------
// console_escape_key_decoder_top
// Turns console bytes into key codes, one byte per cycle unless stalled.
//
//   Channel  Direction  Payload          Handshake
//   req      in         ckd_pkg::req_type  req_valid / req_ready
//   rsp      out        ckd_pkg::rsp_type  rsp_valid / rsp_ready
//
// A byte is registered in the input register on acceptance and parsed from
// there; any key it completes is loaded into the result register when that
// register can load, and rsp_valid is driven from the result register.
// One byte is taken per cycle while the result register can load.
// The sustained rate is set by the single result register: a stalled rsp
// holds off parsing, and req_ready drops while the input register is stalled.
// Synchronous reset clears the parser state and the parameter store.
// ----------------------------------------------------------------------------
module console_escape_key_decoder_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ckd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ckd_pkg::rsp_type rsp_data
);

   ckd_pkg::stage_type  item;
   ckd_pkg::result_type result;
   logic                take;

   // Input register.
   ckd_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .take      (take),
      .item      (item)
   );

   // Parser.
   ckd_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .item   (item),
      .take   (take),
      .result (result)
   );

   // Result register.
   ckd_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .result    (result),
      .take      (take),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
